>>> design/dwp_pkg.sv
`default_nettype none
package dwp_pkg;

	// Field widths
	localparam int COUNT_W = 32;
	localparam int GYRO_W  = 16;
	localparam int MS_W    = 32;
	localparam int SPD_W   = 7;
	localparam int CMD_W   = 8;

	// Derived error widths: two 33-bit deltas plus a 32-bit target, and
	// a 17-bit heading delta against a 16-bit target.
	localparam int DELTA_W = COUNT_W + 1;
	localparam int DERR_W  = COUNT_W + 3;
	localparam int ADIST_W = DERR_W - 1;
	localparam int ROT_W   = GYRO_W + 1;
	localparam int RERR_W  = GYRO_W + 2;
	localparam int AROT_W  = RERR_W - 1;

	// Shared divider: dividend is |span| (7 bit) times an operand of up to
	// 20 bits; the divisor is the brake distance or the ramp time.
	localparam int DIVS_W  = 20;
	localparam int DIVD_W  = SPD_W + DIVS_W;
	localparam int DCNT_W  = $clog2(DIVD_W);
	localparam int PRE_W   = 10;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DISTANCE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ROTATION   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_DEADBAND = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_DISTANCE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX_SPEED   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MIN_SPEED   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_DEADBAND     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME_MS      = 3'd7;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} dwp_div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} dwp_div_rsp_t;

	// Zero stays zero; otherwise a value above hi gives hi, else one below lo gives lo.
	function automatic logic [SPD_W-1:0] clamp_spd(input logic signed [PRE_W-1:0] v,
		input logic [SPD_W-1:0] hi, input logic [SPD_W-1:0] lo);
		logic signed [PRE_W-1:0] hs;
		logic signed [PRE_W-1:0] ls;
		logic [SPD_W-1:0]        r;
		hs = signed'({{(PRE_W-SPD_W){1'b0}}, hi});
		ls = signed'({{(PRE_W-SPD_W){1'b0}}, lo});
		if (v == '0) begin
			r = '0;
		end else if (v > hs) begin
			r = hi;
		end else if (v < ls) begin
			r = lo;
		end else begin
			r = v[SPD_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/dwp_if.sv
`default_nettype none
interface dwp_sample_if import dwp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COUNT_W-1:0] left_count;
	logic signed [COUNT_W-1:0] right_count;
	logic signed [GYRO_W-1:0]  gyro_angle;
	logic [MS_W-1:0]           elapsed_ms;
	logic [MS_W-1:0]           now_ms;

	modport source (output valid, left_count, right_count, gyro_angle, elapsed_ms, now_ms,
		input ready);
	modport sink (input valid, left_count, right_count, gyro_angle, elapsed_ms, now_ms,
		output ready);
endinterface

interface dwp_cmd_if import dwp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [CMD_W-1:0] drive_magnitude;
	logic signed [CMD_W-1:0] turn_rate;
	logic                    finished;

	modport source (output valid, drive_magnitude, turn_rate, finished, input ready);
	modport sink (input valid, drive_magnitude, turn_rate, finished, output ready);
endinterface

interface dwp_cfg_if import dwp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/dwp_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module dwp_div import dwp_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire dwp_div_req_t req,
	output dwp_div_rsp_t      rsp
);

	logic              run_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W:0]   trial;
	logic [DIVS_W:0]   diff;
	logic              fits;

	always_comb begin
		trial = {rem_q, quo_q[DIVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= DCNT_W'(DIVD_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (run_q) begin
			rem_q <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

>>> design/drive_to_waypoint_profiler_core.sv
`default_nettype none
// Steps: an accepted sample word passes delta, error, absolute value and compare,
// then multiply and divide when a braking or ramp quotient is needed, then the
// final step; the quotient comes from a shared restoring divider at one bit per cycle.
// One sample word at a time: ready is high only in idle, and the last step holds
// as long as the previous command word is not taken.
// Reset: all configuration registers take their reset values, the block is
// armed, and no command word is pending.
module drive_to_waypoint_profiler_core import dwp_pkg::*; #(
	parameter int RAMP_TIME_MS     = 500,
	parameter int TURN_BRAKE_ANGLE = 20,
	parameter int TURN_MAX_SPEED   = 80,
	parameter int TURN_MIN_SPEED   = 25,
	parameter bit GYRO_INVERT      = 1'b0
) (
	input wire logic      clk,
	input wire logic      arst_n,
	dwp_sample_if.sink    sample,
	dwp_cmd_if.source     command,
	dwp_cfg_if.sink       cfg
);

	// Sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DELTA = 3'd1;
	localparam logic [2:0] ST_ERR   = 3'd2;
	localparam logic [2:0] ST_ABS   = 3'd3;
	localparam logic [2:0] ST_CMP   = 3'd4;
	localparam logic [2:0] ST_MUL   = 3'd5;
	localparam logic [2:0] ST_DIV   = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	// Drive magnitude source, chosen in the compare step
	localparam logic [1:0] BR_ZERO = 2'd0;
	localparam logic [1:0] BR_MIN  = 2'd1;
	localparam logic [1:0] BR_QUOT = 2'd2;
	localparam logic [1:0] BR_MAX  = 2'd3;

	localparam logic [SPD_W-1:0] TMAX = SPD_W'(TURN_MAX_SPEED);
	localparam logic [SPD_W-1:0] TMIN = SPD_W'(TURN_MIN_SPEED);

	logic [2:0] state_q;

	// Configuration registers
	logic signed [COUNT_W-1:0] tgt_dist_q;
	logic signed [GYRO_W-1:0]  tgt_rot_q;
	logic [15:0]               ddb_q;
	logic [DIVS_W-1:0]         brake_q;
	logic [SPD_W-1:0]          dmax_q;
	logic [SPD_W-1:0]          dmin_q;
	logic [14:0]               tdb_q;
	logic [MS_W-1:0]           hold_q;

	// Tracking state
	logic                      armed_q;
	logic signed [COUNT_W-1:0] base_left_q;
	logic signed [COUNT_W-1:0] base_right_q;
	logic signed [GYRO_W-1:0]  base_head_q;
	logic                      dist_reached_q;
	logic                      head_reached_q;
	logic                      holding_q;
	logic [MS_W-1:0]           hold_start_q;
	logic                      done_q;

	// Per-word working registers
	logic signed [COUNT_W-1:0] left_q;
	logic signed [COUNT_W-1:0] right_q;
	logic signed [GYRO_W-1:0]  gyro_q;
	logic [MS_W-1:0]           elapsed_q;
	logic [MS_W-1:0]           now_q;
	logic signed [DELTA_W-1:0] dl_q;
	logic signed [DELTA_W-1:0] dr_q;
	logic signed [ROT_W-1:0]   rot_q;
	logic signed [DERR_W-1:0]  derr_q;
	logic signed [RERR_W-1:0]  rerr_q;
	logic [ADIST_W-1:0]        adist_q;
	logic [AROT_W-1:0]         arot_q;
	logic [1:0]                br_q;
	logic [SPD_W-1:0]          turn_pre_q;
	logic [DIVS_W-1:0]         mul_val_q;
	logic                      use_ramp_q;

	// Output register
	logic                    res_valid_q;
	logic signed [CMD_W-1:0] res_mag_q;
	logic signed [CMD_W-1:0] res_turn_q;
	logic                    res_fin_q;

	dwp_div_req_t div_req;
	dwp_div_rsp_t div_rsp;

	// Combinational helpers
	logic signed [DERR_W-1:0] dist_sum;
	logic signed [ROT_W-1:0]  rot_raw;
	logic                     in_ddb;
	logic                     in_rdb;
	logic                     dist_r;
	logic                     head_r;
	logic [MS_W-1:0]          hold_elapsed;
	logic                     span_neg;
	logic [SPD_W-1:0]         span_abs;
	logic                     out_free;
	logic signed [PRE_W-1:0]  quot_s;
	logic signed [PRE_W-1:0]  mag_pre;
	logic [SPD_W-1:0]         mag_c;
	logic [SPD_W-1:0]         turn_c;

	assign sample.ready = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign out_free     = !res_valid_q || command.ready;

	always_comb begin
		dist_sum = DERR_W'(dl_q) + DERR_W'(dr_q);
		rot_raw  = ROT_W'(gyro_q) - ROT_W'(base_head_q);
		// Arrival tests; each flag latches once its own test passes
		in_ddb = adist_q < ADIST_W'(ddb_q);
		in_rdb = arot_q < AROT_W'(tdb_q);
		dist_r = dist_reached_q || in_ddb;
		head_r = head_reached_q || in_rdb;
		// Hold timer measured modulo 2^32 from the first on-target word
		hold_elapsed = now_q - (holding_q ? hold_start_q : now_q);
		span_neg = dmin_q > dmax_q;
		span_abs = span_neg ? (dmin_q - dmax_q) : (dmax_q - dmin_q);
	end

	// Shared divider request: |span| * operand over brake distance or ramp time
	always_comb begin
		div_req.start    = (state_q == ST_MUL);
		div_req.dividend = DIVD_W'({{DIVS_W{1'b0}}, span_abs} *
			{{SPD_W{1'b0}}, mul_val_q});
		div_req.divisor  = use_ramp_q ? DIVS_W'(RAMP_TIME_MS) : brake_q;
	end

	dwp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Final drive and turn commands: the quotient is below 127, so its low
	// byte carries it whole.
	always_comb begin
		quot_s = signed'({{(PRE_W-CMD_W){1'b0}}, div_rsp.quotient[CMD_W-1:0]});
		if (span_neg) begin
			quot_s = -quot_s;
		end
		case (br_q)
			BR_ZERO: mag_pre = '0;
			BR_MIN:  mag_pre = signed'({{(PRE_W-SPD_W){1'b0}}, dmin_q});
			BR_QUOT: mag_pre = quot_s + signed'({{(PRE_W-SPD_W){1'b0}}, dmin_q});
			BR_MAX:  mag_pre = signed'({{(PRE_W-SPD_W){1'b0}}, dmax_q});
			default: mag_pre = '0;
		endcase
		mag_c  = clamp_spd(mag_pre, dmax_q, dmin_q);
		turn_c = clamp_spd(signed'({{(PRE_W-SPD_W){1'b0}}, turn_pre_q}), TMAX, TMIN);
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			tgt_dist_q     <= '0;
			tgt_rot_q      <= '0;
			ddb_q          <= 16'd4;
			brake_q        <= DIVS_W'(400);
			dmax_q         <= SPD_W'(127);
			dmin_q         <= SPD_W'(20);
			tdb_q          <= 15'd2;
			hold_q         <= MS_W'(250);
			armed_q        <= 1'b1;
			base_left_q    <= '0;
			base_right_q   <= '0;
			base_head_q    <= '0;
			dist_reached_q <= 1'b0;
			head_reached_q <= 1'b0;
			holding_q      <= 1'b0;
			hold_start_q   <= '0;
			done_q         <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			// Drop the command word once taken
			if (res_valid_q && command.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						// First word after a rearm latches the baselines
						if (armed_q) begin
							base_left_q  <= sample.left_count;
							base_right_q <= sample.right_count;
							base_head_q  <= sample.gyro_angle;
							armed_q      <= 1'b0;
						end
						state_q <= ST_DELTA;
					end
				end
				ST_DELTA: state_q <= ST_ERR;
				ST_ERR:   state_q <= ST_ABS;
				ST_ABS:   state_q <= ST_CMP;
				ST_CMP: begin
					dist_reached_q <= dist_r;
					head_reached_q <= head_r;
					if (dist_r && head_r) begin
						if (in_ddb && in_rdb) begin
							if (!holding_q) begin
								holding_q    <= 1'b1;
								hold_start_q <= now_q;
							end
							if (hold_elapsed > hold_q) begin
								done_q <= 1'b1;
							end
						end else begin
							holding_q <= 1'b0;
						end
						state_q <= ST_FIN;
					end else begin
						done_q <= 1'b0;
						// Braking or ramp needs the divider
						if (!in_ddb && (adist_q < ADIST_W'(brake_q) ||
							elapsed_q < MS_W'(RAMP_TIME_MS))) begin
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_MUL: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// Hold until the output register is free
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// Configuration writes; a target write rearms the block
			if (cfg.valid) begin
				case (cfg.index)
					CFG_TARGET_DISTANCE: begin
						tgt_dist_q     <= signed'(cfg.data[COUNT_W-1:0]);
						armed_q        <= 1'b1;
						dist_reached_q <= 1'b0;
						head_reached_q <= 1'b0;
						holding_q      <= 1'b0;
						done_q         <= 1'b0;
					end
					CFG_TARGET_ROTATION: begin
						tgt_rot_q      <= signed'(cfg.data[GYRO_W-1:0]);
						armed_q        <= 1'b1;
						dist_reached_q <= 1'b0;
						head_reached_q <= 1'b0;
						holding_q      <= 1'b0;
						done_q         <= 1'b0;
					end
					CFG_DISTANCE_DEADBAND: ddb_q   <= cfg.data[15:0];
					CFG_BRAKE_DISTANCE:    brake_q <= cfg.data[DIVS_W-1:0];
					CFG_DRIVE_MAX_SPEED:   dmax_q  <= cfg.data[SPD_W-1:0];
					CFG_DRIVE_MIN_SPEED:   dmin_q  <= cfg.data[SPD_W-1:0];
					CFG_TURN_DEADBAND:     tdb_q   <= cfg.data[14:0];
					CFG_HOLD_TIME_MS:      hold_q  <= cfg.data[MS_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (sample.valid) begin
					left_q    <= sample.left_count;
					right_q   <= sample.right_count;
					gyro_q    <= sample.gyro_angle;
					elapsed_q <= sample.elapsed_ms;
					now_q     <= sample.now_ms;
				end
			end
			ST_DELTA: begin
				// Baselines were latched on acceptance if armed
				dl_q  <= DELTA_W'(left_q) - DELTA_W'(base_left_q);
				dr_q  <= DELTA_W'(right_q) - DELTA_W'(base_right_q);
				rot_q <= GYRO_INVERT ? -rot_raw : rot_raw;
			end
			ST_ERR: begin
				derr_q <= DERR_W'(tgt_dist_q) - dist_sum;
				rerr_q <= RERR_W'(tgt_rot_q) - RERR_W'(rot_q);
			end
			ST_ABS: begin
				adist_q <= derr_q[DERR_W-1] ? ADIST_W'(-derr_q) : ADIST_W'(derr_q);
				arot_q  <= rerr_q[RERR_W-1] ? AROT_W'(-rerr_q) : AROT_W'(rerr_q);
			end
			ST_CMP: begin
				if (dist_r && head_r) begin
					br_q       <= in_ddb ? BR_ZERO : BR_MIN;
					turn_pre_q <= in_rdb ? '0 : TMIN;
				end else begin
					if (in_ddb) begin
						br_q <= BR_ZERO;
					end else if (adist_q < ADIST_W'(brake_q)) begin
						br_q <= BR_QUOT;
					end else if (elapsed_q < MS_W'(RAMP_TIME_MS)) begin
						br_q <= BR_QUOT;
					end else begin
						br_q <= BR_MAX;
					end
					if (in_rdb) begin
						turn_pre_q <= '0;
					end else if (arot_q < AROT_W'(TURN_BRAKE_ANGLE)) begin
						turn_pre_q <= TMIN;
					end else begin
						turn_pre_q <= TMAX;
					end
				end
				// Operand for the quotient: braking wins over ramp
				use_ramp_q <= !(adist_q < ADIST_W'(brake_q));
				mul_val_q  <= (adist_q < ADIST_W'(brake_q)) ? adist_q[DIVS_W-1:0] :
					elapsed_q[DIVS_W-1:0];
			end
			ST_FIN: begin
				if (out_free) begin
					res_mag_q  <= derr_q[DERR_W-1] ? -signed'({1'b0, mag_c}) :
						signed'({1'b0, mag_c});
					res_turn_q <= rerr_q[RERR_W-1] ? -signed'({1'b0, turn_c}) :
						signed'({1'b0, turn_c});
					res_fin_q  <= done_q;
				end
			end
			default: ;
		endcase
	end

	assign command.valid           = res_valid_q;
	assign command.drive_magnitude = res_mag_q;
	assign command.turn_rate       = res_turn_q;
	assign command.finished        = res_fin_q;

endmodule
`default_nettype wire
